FILE: src/pfe_pkg.sv
// Package for the postfix expression evaluator.
// Holds the character codes, status and operator codes, FSM states and the
// request struct to the arithmetic unit. Depends on nothing.
package pfe_pkg;

    // ASCII codes recognised in the input stream.
    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] DIGIT_NINE = 8'd57;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_TIMES  = 8'h2A;
    localparam logic [7:0] SYM_DIVIDE = 8'h2F;

    // Sticky status reported with each result item.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_DIVZERO   = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    // Binary operators.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_FETCH,
        ST_OUTPUT
    } state_t;

    // Request to the iterative multiply/divide unit.
    typedef struct packed {
        logic start;
        logic div;
    } alu_req_t;

endpackage

FILE: src/pfe_stack_mem.sv
// Operand stack storage: one write port and two registered read ports.
// Depends on nothing; contents are undefined until written.
module pfe_stack_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: src/pfe_alu.sv
// Iterative multiply and truncating signed divide, one bit per cycle.
// Depends on pfe_pkg for the request struct.
module pfe_alu
    import pfe_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [WIDTH-1:0] opnd_a,
    input  logic [WIDTH-1:0] opnd_b,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] opa_reg, opa_next;
    logic [WIDTH-1:0] opb_reg, opb_next;

    logic             a_neg, b_neg;
    logic [WIDTH-1:0] a_abs, b_abs;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_sub;
    logic             rem_ge;

    // Magnitudes of the operands for division.
    assign a_neg = opnd_a[WIDTH-1];
    assign b_neg = opnd_b[WIDTH-1];
    assign a_abs = a_neg ? (WIDTH'(0) - opnd_a) : opnd_a;
    assign b_abs = b_neg ? (WIDTH'(0) - opnd_b) : opnd_b;

    // One restoring division step.
    assign rem_shift = {acc_reg, opa_reg[WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, opb_reg};
    assign rem_ge    = (rem_shift >= {1'b0, opb_reg});

    // Step logic for both operations.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.div;
            cnt_next  = '0;
            acc_next  = '0;
            if (req.div)
            begin
                neg_next = a_neg ^ b_neg;
                opa_next = a_abs;
                opb_next = b_abs;
            end
            else
            begin
                neg_next = 1'b0;
                opa_next = opnd_a;
                opb_next = opnd_b;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg)
            begin
                acc_next = rem_ge ? rem_sub[WIDTH-1:0] : rem_shift[WIDTH-1:0];
                opa_next = {opa_reg[WIDTH-2:0], rem_ge};
            end
            else
            begin
                acc_next = opb_reg[0] ? (acc_reg + opa_reg) : acc_reg;
                opa_next = {opa_reg[WIDTH-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[WIDTH-1:1]};
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (WIDTH'(0) - opa_reg) : opa_reg) : acc_reg;

endmodule

FILE: src/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: sequencer and stack pointer.
// Depends on pfe_pkg, pfe_stack_mem and pfe_alu.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_ready  | symbol[7:0], end_of_expression
//  out     | output    | out_valid/out_ready| value[31:0] signed, status[1:0]
//
// A digit, an ignored character or an operator short of operands is handled in
// the idle state; + and -, and a division by zero, also pass the execute state;
// * and / otherwise also wait in the wait state for the one-bit-per-cycle unit.
// The item marked last passes the fetch state, reading the top of the stack
// from the memory port, and the output state, loading the output register.
// Reset clears the stack pointer, the status and the output valid flag; the
// stack memory itself is not cleared. Items are taken while a result waits;
// only the loading of a new result stalls until the previous one is taken.
module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         symbol,
    input  logic               end_of_expression,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [SPW-1:0]          sp_reg, sp_next;
    status_t                 err_reg, err_next;
    op_t                     op_reg, op_next;
    logic                    last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [31:0]      value_reg, value_next;
    status_t                 status_reg, status_next;

    logic [SPW-1:0]          sp_m1, sp_m2;
    logic                    accept;
    logic                    is_digit, is_op, stack_full, too_few;
    op_t                     op_dec;
    logic                    out_load;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VALUE_WIDTH-1:0]  mem_wdata;
    logic [AW-1:0]           mem_raddr_a, mem_raddr_b;
    logic [VALUE_WIDTH-1:0]  mem_rdata_a, mem_rdata_b;

    alu_req_t                alu_req;
    logic                    alu_done;
    logic [VALUE_WIDTH-1:0]  alu_result;

    // Decode of the incoming character.
    assign accept     = in_valid && in_ready;
    assign is_digit   = (symbol >= DIGIT_ZERO) && (symbol <= DIGIT_NINE);
    assign is_op      = (symbol == SYM_PLUS) || (symbol == SYM_MINUS) ||
                        (symbol == SYM_TIMES) || (symbol == SYM_DIVIDE);
    assign stack_full = (sp_reg == SPW'(STACK_DEPTH));
    assign too_few    = (sp_reg < SPW'(2));
    assign sp_m1      = sp_reg - SPW'(1);
    assign sp_m2      = sp_reg - SPW'(2);
    assign out_load   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (symbol)
            SYM_PLUS:  op_dec = OP_ADD;
            SYM_MINUS: op_dec = OP_SUB;
            SYM_TIMES: op_dec = OP_MUL;
            default:   op_dec = OP_DIV;
        endcase
    end

    // Read addresses: both operands when idle, otherwise the top entry.
    assign mem_raddr_a = (state_reg == ST_IDLE) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
    assign mem_raddr_b = sp_m1[AW-1:0];

    pfe_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_stack (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    pfe_alu #(
        .WIDTH (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opnd_a (mem_rdata_a),
        .opnd_b (mem_rdata_b),
        .done   (alu_done),
        .result (alu_result)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_op && !too_few)
                    begin
                        state_next = ST_EXEC;
                    end
                    else if (end_of_expression)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_MUL || (op_reg == OP_DIV && mem_rdata_b != '0))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = last_reg ? ST_FETCH : ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = last_reg ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic of the sequencer.
    always_comb
    begin
        in_ready       = 1'b0;
        sp_next        = sp_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = sp_m2[AW-1:0];
        mem_wdata      = alu_result;
        alu_req.start  = 1'b0;
        alu_req.div    = (op_reg == OP_DIV);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    op_next   = op_dec;
                    last_next = end_of_expression;
                    if (is_digit)
                    begin
                        if (stack_full)
                        begin
                            if (err_reg == STATUS_OK)
                            begin
                                err_next = STATUS_OVERFLOW;
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = sp_reg[AW-1:0];
                            mem_wdata = VALUE_WIDTH'(symbol[3:0]);
                            sp_next   = sp_reg + SPW'(1);
                        end
                    end
                    else if (is_op && too_few)
                    begin
                        if (err_reg == STATUS_OK)
                        begin
                            err_next = STATUS_UNDERFLOW;
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata_a + mem_rdata_b;
                        sp_next   = sp_m1;
                    end
                    OP_SUB:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata_a - mem_rdata_b;
                        sp_next   = sp_m1;
                    end
                    OP_MUL:
                    begin
                        alu_req.start = 1'b1;
                    end
                    default:
                    begin
                        if (mem_rdata_b == '0)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '0;
                            sp_next   = sp_m1;
                            if (err_reg == STATUS_OK)
                            begin
                                err_next = STATUS_DIVZERO;
                            end
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                        end
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    mem_we  = 1'b1;
                    sp_next = sp_m1;
                end
            end
            ST_FETCH:
            begin
                // Top entry read is issued here, after any pending write.
            end
            ST_OUTPUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    value_next     = (sp_reg == '0) ? 32'sd0 : 32'($signed(mem_rdata_a));
                    status_next    = err_reg;
                    sp_next        = '0;
                    err_next       = STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        last_reg   <= last_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // The stack pointer never passes the depth of the stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // The arithmetic unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished outside the wait state");

    // Loading a result empties the stack and presents the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUTPUT && out_load) |=> (sp_reg == '0 && out_valid_reg))
        else $error("result load did not clear the stack");

    // A new item is only taken in the idle state, which never leads directly to the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_OUTPUT))
        else $error("item taken while a result was being formed");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the postfix expression evaluator.
// Holds a scoreboard class that predicts each result item from the accepted
// symbols, and the tasks that drive the block. Depends on pfe_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top
    import pfe_pkg::*;
;

    localparam int STACK_DEPTH = 16;
    localparam int SYMBOL_TARGET = 1400;

    // One expected result item: top of stack and sticky status.
    typedef struct {
        logic [31:0] value;
        status_t     status;
    } expr_result_t;

    // Tracks the operand stack and the status, and checks every result item.
    class rpn_scoreboard;
        logic [31:0]  operands [STACK_DEPTH];
        int unsigned  depth_used;
        status_t      sticky_status;
        expr_result_t expected_results [$];
        int unsigned  mismatch_count;

        function new();
            depth_used = 0;
            sticky_status = STATUS_OK;
            mismatch_count = 0;
        endfunction

        // Only the first error of an expression is kept.
        function void flag_error(status_t code);
            if (sticky_status == STATUS_OK)
                sticky_status = code;
        endfunction

        // Applies one accepted symbol and queues a result on the last one.
        function void note_input(logic [7:0] sym, logic last);
            logic [31:0]  lhs;
            logic [31:0]  rhs;
            logic [31:0]  res;
            expr_result_t item;
            if (sym >= DIGIT_ZERO && sym <= DIGIT_NINE)
            begin
                // A digit is dropped when the stack is full.
                if (depth_used >= STACK_DEPTH)
                    flag_error(STATUS_OVERFLOW);
                else
                begin
                    operands[depth_used] = 32'(sym - DIGIT_ZERO);
                    depth_used++;
                end
            end
            else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_TIMES ||
                     sym == SYM_DIVIDE)
            begin
                if (depth_used < 2)
                    flag_error(STATUS_UNDERFLOW);
                else
                begin
                    rhs = operands[depth_used - 1];
                    lhs = operands[depth_used - 2];
                    depth_used -= 2;
                    case (sym)
                        SYM_PLUS:  res = lhs + rhs;
                        SYM_MINUS: res = lhs - rhs;
                        SYM_TIMES: res = lhs * rhs;
                        default:
                        begin
                            // Widened so that the most negative value over -1 wraps.
                            if (rhs == '0)
                            begin
                                flag_error(STATUS_DIVZERO);
                                res = '0;
                            end
                            else
                                res = 32'(longint'($signed(lhs)) / longint'($signed(rhs)));
                        end
                    endcase
                    operands[depth_used] = res;
                    depth_used++;
                end
            end
            if (last)
            begin
                item.value = (depth_used > 0) ? operands[depth_used - 1] : '0;
                item.status = sticky_status;
                expected_results.push_back(item);
                depth_used = 0;
                sticky_status = STATUS_OK;
            end
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // Compares a result item with the oldest expectation, field by field.
        task check_result(logic [31:0] got_value, logic [1:0] got_status);
            expr_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: value %0d status %0d",
                                          $signed(got_value), got_status));
                return;
            end
            want = expected_results.pop_front();
            if (got_value !== want.value)
                report_mismatch($sformatf("value %0d, expected %0d",
                                          $signed(got_value), $signed(want.value)));
            if (got_status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got_status, want.status));
        endtask
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         symbol = '0;
    logic               end_of_expression = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] value;
    logic [1:0]         status;

    rpn_scoreboard board = new();
    int unsigned   burst_left = 0;
    int unsigned   evaluated_symbols = 0;
    int unsigned   ready_mode = 0;
    int unsigned   ready_phase_left = 0;
    int unsigned   ready_tick = 0;
    logic [7:0]    operators [4] = '{SYM_PLUS, SYM_MINUS, SYM_TIMES, SYM_DIVIDE};

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH),
        .VALUE_WIDTH(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .symbol(symbol),
        .end_of_expression(end_of_expression),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value(value),
        .status(status)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver switches between steady, loose, heavy and periodic stalling.
    always @(negedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_phase_left = $urandom_range(20, 200);
        end
        ready_phase_left--;
        ready_tick++;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ready_tick[2];
        endcase
    end

    // Result items are checked as they are accepted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(value, status);
    end

    // Sends one item; the sender works in bursts separated by random gaps.
    task automatic send_item(logic [7:0] sym, logic last);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4))
                @(negedge clk);
            burst_left = $urandom_range(1, 60);
        end
        in_valid <= 1'b1;
        symbol <= sym;
        end_of_expression <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(sym, last);
        if ((sym >= DIGIT_ZERO && sym <= DIGIT_NINE) || sym == SYM_PLUS ||
            sym == SYM_MINUS || sym == SYM_TIMES || sym == SYM_DIVIDE)
            evaluated_symbols++;
        burst_left--;
        @(negedge clk);
    endtask

    // Sends a whole expression written as text, the final character marked last.
    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], i == text.len() - 1);
    endtask

    // Builds one random expression: mostly well formed, some deep, noisy or broken.
    task automatic send_random_expression();
        logic [7:0]  chars [$];
        int unsigned style;
        int unsigned operand_goal;
        int unsigned pushed;
        int unsigned depth;
        style = $urandom_range(0, 19);
        if (style < 14)
        begin
            operand_goal = $urandom_range(1, 10);
            pushed = 0;
            depth = 0;
            while (pushed < operand_goal || depth > 1)
            begin
                if (pushed < operand_goal && (depth < 2 || $urandom_range(0, 1) == 1))
                begin
                    chars.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                    pushed++;
                    depth++;
                end
                else
                begin
                    chars.push_back(operators[$urandom_range(0, 3)]);
                    depth--;
                end
                if ($urandom_range(0, 15) == 0)
                    chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (style < 16)
        begin
            // Deep pushes that can run into a full stack.
            repeat ($urandom_range(14, 20))
                chars.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 20))
                chars.push_back(operators[$urandom_range(0, 3)]);
        end
        else if (style < 18)
        begin
            repeat ($urandom_range(1, 8))
                chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Digits and operators in any order, often short of operands.
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 1) == 1)
                    chars.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                else
                    chars.push_back(operators[$urandom_range(0, 3)]);
            end
        end
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1);
    endtask

    // Reset, directed expressions, random expressions, then drain.
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A lone number, and an empty expression made of the extreme codes.
        send_text("7");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // Each operator, negative truncation and division by zero.
        send_text("98+");
        send_text("35-");
        send_text("96*");
        send_text("83/");
        send_text("07-2/");
        send_text("70/");
        // Underflow with an empty and a one-entry stack; first error is kept.
        send_text("+");
        send_text("5+");
        send_text("70/+");
        // Extra operands left over, with ignored spaces.
        send_text("1 2+3");
        // Seventeen digits overflow the stack.
        send_text("99999999999999999+");
        // The most negative value divided by minus one wraps.
        send_text("88*8*8*8*8*8*8*8*8*2*01-/");

        while (evaluated_symbols < SYMBOL_TARGET)
            send_random_expression();
        in_valid <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: postfix_expression_evaluator.f
src/pfe_pkg.sv
src/pfe_stack_mem.sv
src/pfe_alu.sv
src/postfix_expression_evaluator.sv
dv/tb_top.sv
